>>> rtl/core/vrp_pkg.sv
// Package for the vertex rotate, project and viewport block.
// Holds the shared widths, register indexes and stage payload types.
// No dependencies.
`default_nettype none
package vrp_pkg;

  localparam int unsigned COORD_FRAC_BITS = 8;
  localparam int unsigned TRIG_FRAC_BITS  = 14;

  localparam int unsigned ROT_W  = 49;
  localparam int unsigned NUM_W  = 64;
  localparam int unsigned MAG_W  = 63;
  localparam int unsigned DEN_W  = 48;
  localparam int unsigned DIV_W  = 66;
  localparam int unsigned QUO_W  = 17;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_COS    = 3'd0;
  localparam logic [IDX_W-1:0] REG_SIN    = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET = 3'd2;
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd4;
  localparam logic [IDX_W-1:0] REG_LEFT   = 3'd5;
  localparam logic [IDX_W-1:0] REG_TOP    = 3'd6;

  localparam logic signed [15:0] RST_COS    = 16'sd16384;
  localparam logic signed [15:0] RST_SIN    = 16'sd0;
  localparam logic signed [15:0] RST_OFFSET = 16'(15 << COORD_FRAC_BITS);
  localparam logic [12:0]        RST_WIDTH  = 13'd640;
  localparam logic [12:0]        RST_HEIGHT = 13'd480;

  typedef struct packed {
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic signed [15:0] depth_offset;
    logic [12:0]        view_width;
    logic [12:0]        view_height;
    logic [11:0]        view_left;
    logic [11:0]        view_top;
  } cfg_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x2;
    logic signed [ROT_W-1:0] y2;
    logic signed [ROT_W-1:0] d;
  } rot_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic             neg_x;
    logic             neg_y;
    logic [DEN_W-1:0] den;
    logic             fault;
  } num_t;

  typedef struct packed {
    logic [MAG_W-1:0] rem_x;
    logic [MAG_W-1:0] rem_y;
    logic [QUO_W-1:0] quo_x;
    logic [QUO_W-1:0] quo_y;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic [DEN_W-1:0] den;
    logic             fault;
  } div_t;

endpackage
`default_nettype wire

>>> rtl/core/vrp_rotate.sv
// Rotation about X then Y and depth offset, four register stages.
// Depends on vrp_pkg.
`default_nettype none
module vrp_rotate (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire vrp_pkg::cfg_t      cfg_i,
  input  wire logic               valid_i,
  input  wire logic signed [15:0] x_i,
  input  wire logic signed [15:0] y_i,
  input  wire logic signed [15:0] z_i,
  output logic                    valid_o,
  output vrp_pkg::rot_t           rot_o
);

  logic [3:0] valid_q;
  logic signed [31:0] xc1_q, xs1_q, yc1_q, zs1_q, ys1_q, zc1_q;
  logic signed [32:0] y1_q, z1_q;
  logic signed [31:0] xc2_q, xs2_q;
  logic signed [vrp_pkg::ROT_W-1:0] zs3_q, zc3_q, zs3_d, zc3_d;
  logic signed [31:0] xc3_q, xs3_q;
  logic signed [32:0] y13_q;
  vrp_pkg::rot_t rot_q, rot_d;

  assign zs3_d = z1_q * cfg_i.sin_angle;
  assign zc3_d = z1_q * cfg_i.cos_angle;

  always_comb begin
    rot_d.x2 = (vrp_pkg::ROT_W'(xc3_q) <<< vrp_pkg::TRIG_FRAC_BITS) + zs3_q;
    rot_d.y2 = vrp_pkg::ROT_W'(y13_q) <<< vrp_pkg::TRIG_FRAC_BITS;
    rot_d.d  = zc3_q - (vrp_pkg::ROT_W'(xs3_q) <<< vrp_pkg::TRIG_FRAC_BITS)
             + (vrp_pkg::ROT_W'(cfg_i.depth_offset) <<< (2 * vrp_pkg::TRIG_FRAC_BITS));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    xc1_q <= x_i * cfg_i.cos_angle;
    xs1_q <= x_i * cfg_i.sin_angle;
    yc1_q <= y_i * cfg_i.cos_angle;
    zs1_q <= z_i * cfg_i.sin_angle;
    ys1_q <= y_i * cfg_i.sin_angle;
    zc1_q <= z_i * cfg_i.cos_angle;
    y1_q  <= 33'(yc1_q) - 33'(zs1_q);
    z1_q  <= 33'(ys1_q) + 33'(zc1_q);
    xc2_q <= xc1_q;
    xs2_q <= xs1_q;
    zs3_q <= zs3_d;
    zc3_q <= zc3_d;
    xc3_q <= xc2_q;
    xs3_q <= xs2_q;
    y13_q <= y1_q;
    rot_q <= rot_d;
  end

  assign valid_o = valid_q[3];
  assign rot_o   = rot_q;

endmodule
`default_nettype wire

>>> rtl/core/vrp_project.sv
// Projection numerators and denominator, three register stages.
// Depends on vrp_pkg.
`default_nettype none
module vrp_project (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire vrp_pkg::cfg_t cfg_i,
  input  wire logic          valid_i,
  input  wire vrp_pkg::rot_t rot_i,
  output logic               valid_o,
  output vrp_pkg::num_t      num_o
);

  localparam int unsigned NW = vrp_pkg::NUM_W;

  logic [2:0] valid_q;
  logic signed [13:0] ox, oy, hs;
  logic signed [vrp_pkg::ROT_W:0] den;
  logic signed [NW-1:0] px_q, py_q, oxd_q, oyd_q;
  logic signed [NW-1:0] nx_q, ny_q;
  logic [vrp_pkg::DEN_W-1:0] den5_q, den6_q;
  logic fault5_q, fault6_q;
  vrp_pkg::num_t num_q, num_d;

  assign ox  = $signed({2'b00, cfg_i.view_left} + {2'b00, cfg_i.view_width[12:1]});
  assign oy  = $signed({2'b00, cfg_i.view_top} + {2'b00, cfg_i.view_height[12:1]});
  assign hs  = $signed({1'b0, cfg_i.view_height});
  assign den = (vrp_pkg::ROT_W+1)'(rot_i.d) <<< 1;

  always_comb begin
    num_d.neg_x = nx_q[NW-1];
    num_d.neg_y = ny_q[NW-1];
    num_d.mag_x = vrp_pkg::MAG_W'(nx_q[NW-1] ? -nx_q : nx_q);
    num_d.mag_y = vrp_pkg::MAG_W'(ny_q[NW-1] ? -ny_q : ny_q);
    num_d.den   = den6_q;
    num_d.fault = fault6_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    px_q     <= NW'(rot_i.x2) * NW'(hs);
    py_q     <= NW'(rot_i.y2) * NW'(hs);
    oxd_q    <= NW'(den) * NW'(ox);
    oyd_q    <= NW'(den) * NW'(oy);
    den5_q   <= vrp_pkg::DEN_W'(den);
    fault5_q <= (rot_i.d <= 0);
    nx_q     <= px_q + oxd_q;
    ny_q     <= oyd_q - py_q;
    den6_q   <= den5_q;
    fault6_q <= fault5_q;
    num_q    <= num_d;
  end

  assign valid_o = valid_q[2];
  assign num_o   = num_q;

endmodule
`default_nettype wire

>>> rtl/core/vrp_div.sv
// Pipelined restoring divider for both screen axes, one quotient bit a stage.
// Depends on vrp_pkg.
`default_nettype none
module vrp_div (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire vrp_pkg::num_t num_i,
  output logic               valid_o,
  output vrp_pkg::div_t      div_o
);

  localparam int unsigned QW = vrp_pkg::QUO_W;
  localparam int unsigned DW = vrp_pkg::DIV_W;

  vrp_pkg::div_t st_in;
  vrp_pkg::div_t st_q [1:QW];
  logic [QW-1:0] valid_q;

  always_comb begin
    st_in.rem_x = num_i.mag_x;
    st_in.rem_y = num_i.mag_y;
    st_in.quo_x = '0;
    st_in.quo_y = '0;
    st_in.neg_x = num_i.neg_x;
    st_in.neg_y = num_i.neg_y;
    st_in.ovf_x = (DW'(num_i.mag_x) >= (DW'(num_i.den) << QW));
    st_in.ovf_y = (DW'(num_i.mag_y) >= (DW'(num_i.den) << QW));
    st_in.den   = num_i.den;
    st_in.fault = num_i.fault;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[QW-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int unsigned B = QW - 1 - k;
    vrp_pkg::div_t cur;
    vrp_pkg::div_t nxt;
    logic [DW-1:0] dsh;

    if (k == 0) begin : g_first
      assign cur = st_in;
    end else begin : g_next
      assign cur = st_q[k];
    end

    assign dsh = DW'(cur.den) << B;

    always_comb begin
      nxt = cur;
      if (DW'(cur.rem_x) >= dsh) begin
        nxt.rem_x    = vrp_pkg::MAG_W'(DW'(cur.rem_x) - dsh);
        nxt.quo_x[B] = 1'b1;
      end
      if (DW'(cur.rem_y) >= dsh) begin
        nxt.rem_y    = vrp_pkg::MAG_W'(DW'(cur.rem_y) - dsh);
        nxt.quo_y[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k+1] <= nxt;
    end
  end

  assign valid_o = valid_q[QW-1];
  assign div_o   = st_q[QW];

endmodule
`default_nettype wire

>>> rtl/core/vertex_rotate_project_viewport.sv
// Top level: configuration registers, rotate, project, divide, saturate.
// The done strobe for an accepted start passes the rotate, project, divide and output
// registers in that order; one transaction is accepted in every cycle by the datapath pipeline.
// The receiver cannot stall, so busy_o is always low.
// Reset clears the pipeline valid bits and loads the register defaults.
// Depends on vrp_pkg, vrp_rotate, vrp_project and vrp_div.
`default_nettype none
module vertex_rotate_project_viewport (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic signed [15:0]           vertex_x_i,
  input  wire logic signed [15:0]           vertex_y_i,
  input  wire logic signed [15:0]           vertex_z_i,
  output logic                              done_o,
  output logic signed [15:0]                screen_x_o,
  output logic signed [15:0]                screen_y_o,
  output logic                              depth_fault_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [vrp_pkg::IDX_W-1:0]    cfg_idx_i,
  input  wire logic [15:0]                  cfg_data_i
);

  localparam int unsigned LAT = 25;

  vrp_pkg::cfg_t cfg_q;
  logic          rot_valid, num_valid, div_valid;
  vrp_pkg::rot_t rot;
  vrp_pkg::num_t num;
  vrp_pkg::div_t div;
  logic          done_q;
  logic signed [15:0] sx_q, sy_q, sx_d, sy_d;
  logic          fault_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_angle    <= vrp_pkg::RST_COS;
      cfg_q.sin_angle    <= vrp_pkg::RST_SIN;
      cfg_q.depth_offset <= vrp_pkg::RST_OFFSET;
      cfg_q.view_width   <= vrp_pkg::RST_WIDTH;
      cfg_q.view_height  <= vrp_pkg::RST_HEIGHT;
      cfg_q.view_left    <= '0;
      cfg_q.view_top     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vrp_pkg::REG_COS:    cfg_q.cos_angle    <= $signed(cfg_data_i);
        vrp_pkg::REG_SIN:    cfg_q.sin_angle    <= $signed(cfg_data_i);
        vrp_pkg::REG_OFFSET: cfg_q.depth_offset <= $signed(cfg_data_i);
        vrp_pkg::REG_WIDTH:  cfg_q.view_width   <= cfg_data_i[12:0];
        vrp_pkg::REG_HEIGHT: cfg_q.view_height  <= cfg_data_i[12:0];
        vrp_pkg::REG_LEFT:   cfg_q.view_left    <= cfg_data_i[11:0];
        vrp_pkg::REG_TOP:    cfg_q.view_top     <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  vrp_rotate u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (start_i && !busy_o),
    .x_i     (vertex_x_i),
    .y_i     (vertex_y_i),
    .z_i     (vertex_z_i),
    .valid_o (rot_valid),
    .rot_o   (rot)
  );

  vrp_project u_project (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (rot_valid),
    .rot_i   (rot),
    .valid_o (num_valid),
    .num_o   (num)
  );

  vrp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (num_valid),
    .num_i   (num),
    .valid_o (div_valid),
    .div_o   (div)
  );

  always_comb begin
    if (div.neg_x) begin
      sx_d = (div.ovf_x || div.quo_x > 17'd32768) ? 16'sh8000 : 16'(-div.quo_x);
    end else begin
      sx_d = (div.ovf_x || div.quo_x > 17'd32767) ? 16'sh7FFF : 16'(div.quo_x);
    end
    if (div.neg_y) begin
      sy_d = (div.ovf_y || div.quo_y > 17'd32768) ? 16'sh8000 : 16'(-div.quo_y);
    end else begin
      sy_d = (div.ovf_y || div.quo_y > 17'd32767) ? 16'sh7FFF : 16'(div.quo_y);
    end
    if (div.fault) begin
      sx_d = '0;
      sy_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    fault_q <= div.fault;
  end

  assign done_o        = done_q;
  assign screen_x_o    = sx_q;
  assign screen_y_o    = sy_q;
  assign depth_fault_o = fault_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("accepted transaction did not complete on time");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("done strobe without a matching transaction");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && depth_fault_o) |-> (screen_x_o == 16'sd0 && screen_y_o == 16'sd0))
    else $error("depth fault with non-zero coordinates");

endmodule
`default_nettype wire
